// ----- rtl/afom_pkg.sv -----
// Shared types and constants of the ADC frame on-time meter.
// No dependencies; every other file of the block imports this package.
package afom_pkg;

	localparam int TIME_WIDTH   = 48;
	localparam int SAMPLE_WIDTH = 12;
	localparam int FRAME_WIDTH  = 32;
	localparam int NUM_CHAN     = 2;
	localparam int CHAN_WIDTH   = $clog2(NUM_CHAN);
	localparam int CFG_IDX_WIDTH  = 1;
	localparam int CFG_DATA_WIDTH = SAMPLE_WIDTH;

	// null bit: bit 5 of the first byte
	localparam int NULL_BIT_POS = FRAME_WIDTH - 8 + 5;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_CLEAR  = 1'b1
	} op_t;

	localparam logic [CFG_IDX_WIDTH-1:0] REG_FLOOR_CHAN0 = 1'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_FLOOR_CHAN1 = 1'd1;

	typedef struct packed {
		logic                   operation;
		logic [CHAN_WIDTH-1:0]  channel;
		logic [FRAME_WIDTH-1:0] frame;
		logic [TIME_WIDTH-1:0]  timestamp_ms;
	} in_item_t;

	typedef struct packed {
		logic                    frame_error;
		logic [SAMPLE_WIDTH-1:0] sample_msb_first;
		logic [SAMPLE_WIDTH-1:0] sample_lsb_first;
		logic                    channel_on;
		logic [TIME_WIDTH-1:0]   run_time_ms;
		logic [TIME_WIDTH-1:0]   unreported_ms;
	} out_item_t;

	// classified beat handed from the front to the back
	typedef struct packed {
		op_t                     op;
		logic [CHAN_WIDTH-1:0]   channel;
		logic                    frame_error;
		logic                    above_floor;
		logic [SAMPLE_WIDTH-1:0] sample_msb;
		logic [SAMPLE_WIDTH-1:0] sample_lsb;
		logic [TIME_WIDTH-1:0]   timestamp;
	} work_item_t;

	// bit i of the result is bit (11 - i) of {b1[1:0], b2, b3[7:6]}
	function automatic logic [SAMPLE_WIDTH-1:0] bit_reverse12(
		input logic [SAMPLE_WIDTH-1:0] src
	);
		logic [SAMPLE_WIDTH-1:0] r;
		for (int i = 0; i < SAMPLE_WIDTH; i++) begin
			r[i] = src[SAMPLE_WIDTH-1-i];
		end
		return r;
	endfunction

endpackage

// ----- rtl/afom_front.sv -----
// Front end: floor registers, frame null-bit check, sample unpack, floor compare.
// Depends on afom_pkg.
module afom_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  afom_pkg::in_item_t                    in_data,
	input  logic                                  cfg_we,
	input  logic [afom_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
	input  logic [afom_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
	output afom_pkg::work_item_t                  item
);
	import afom_pkg::*;

	logic [SAMPLE_WIDTH-1:0] floor_q [NUM_CHAN];
	logic [SAMPLE_WIDTH-1:0] msb_raw;
	logic [SAMPLE_WIDTH-1:0] lsb_raw;
	logic                    null_bit;
	logic                    is_clear;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q[0] <= '0;
			floor_q[1] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FLOOR_CHAN0: floor_q[0] <= cfg_data;
				REG_FLOOR_CHAN1: floor_q[1] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		is_clear = (op_t'(in_data.operation) == OP_CLEAR);
		null_bit = in_data.frame[NULL_BIT_POS];
		// (b0 & 0x1F) << 7 | b1 >> 1
		msb_raw  = {in_data.frame[28:24], in_data.frame[23:17]};
		lsb_raw  = bit_reverse12({in_data.frame[17:16], in_data.frame[15:8],
			in_data.frame[7:6]});

		item.op          = op_t'(in_data.operation);
		item.channel     = in_data.channel;
		item.frame_error = !is_clear && null_bit;
		item.above_floor = msb_raw > floor_q[in_data.channel];
		item.timestamp   = in_data.timestamp_ms;
		if (is_clear || null_bit) begin
			item.sample_msb = '0;
			item.sample_lsb = '0;
		end else begin
			item.sample_msb = msb_raw;
			item.sample_lsb = lsb_raw;
		end
	end

endmodule

// ----- rtl/afom_queue.sv -----
// Two-entry queue between the front end and the channel update stage.
// Depends on afom_pkg.
module afom_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  afom_pkg::work_item_t  push_item,
	output logic                  full,
	input  logic                  pop,
	output logic                  not_empty,
	output afom_pkg::work_item_t  head
);
	import afom_pkg::*;

	localparam int DEPTH = 2;

	work_item_t                 mem [DEPTH];
	logic                       wr_ptr_q;
	logic                       rd_ptr_q;
	logic [$clog2(DEPTH+1)-1:0] count_q;

	assign full      = (count_q == 2'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/afom_back.sv -----
// Back end: per-channel on-time state update and the registered result beat.
// Depends on afom_pkg.
module afom_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  afom_pkg::work_item_t  item,
	output logic                  item_pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output afom_pkg::out_item_t   out_data
);
	import afom_pkg::*;

	localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

	logic [TIME_WIDTH-1:0] last_on_time_q [NUM_CHAN];
	logic                  last_on_valid_q [NUM_CHAN];
	logic [TIME_WIDTH-1:0] run_time_q [NUM_CHAN];
	logic [TIME_WIDTH-1:0] unrep_q [NUM_CHAN];

	logic                  out_valid_q;
	out_item_t             out_data_q;

	logic [TIME_WIDTH-1:0] cur_last;
	logic                  cur_on;
	logic [TIME_WIDTH-1:0] cur_run;
	logic [TIME_WIDTH-1:0] cur_unrep;
	logic [TIME_WIDTH-1:0] dur;
	logic [TIME_WIDTH-1:0] run_next;
	logic [TIME_WIDTH-1:0] unrep_next;
	out_item_t             res;

	function automatic logic [TIME_WIDTH-1:0] sat_add(
		input logic [TIME_WIDTH-1:0] a,
		input logic [TIME_WIDTH-1:0] b
	);
		logic [TIME_WIDTH:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_WIDTH] ? TIME_MAX : s[TIME_WIDTH-1:0];
	endfunction

	assign item_pop  = item_valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		cur_last  = last_on_time_q[item.channel];
		cur_on    = last_on_valid_q[item.channel];
		cur_run   = run_time_q[item.channel];
		cur_unrep = unrep_q[item.channel];

		if (!cur_on) begin
			dur = TIME_WIDTH'(1);
		end else if (item.timestamp >= cur_last) begin
			dur = item.timestamp - cur_last;
		end else begin
			dur = '0;
		end
		run_next   = sat_add(cur_run, dur);
		unrep_next = sat_add(cur_unrep, dur);

		res.frame_error      = item.frame_error;
		res.sample_msb_first = item.sample_msb;
		res.sample_lsb_first = item.sample_lsb;
		res.channel_on       = cur_on;
		res.run_time_ms      = cur_run;
		res.unreported_ms    = cur_unrep;
		if (item.op == OP_CLEAR) begin
			res.unreported_ms = '0;
		end else if (!item.frame_error) begin
			if (item.above_floor) begin
				res.channel_on    = 1'b1;
				res.run_time_ms   = run_next;
				res.unreported_ms = unrep_next;
			end else begin
				res.channel_on  = 1'b0;
				res.run_time_ms = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CHAN; c++) begin
				last_on_time_q[c]  <= '0;
				last_on_valid_q[c] <= 1'b0;
				run_time_q[c]      <= '0;
				unrep_q[c]         <= '0;
			end
		end else if (item_pop) begin
			if (item.op == OP_CLEAR) begin
				for (int c = 0; c < NUM_CHAN; c++) begin
					unrep_q[c] <= '0;
				end
			end else if (!item.frame_error) begin
				if (item.above_floor) begin
					run_time_q[item.channel]      <= run_next;
					unrep_q[item.channel]         <= unrep_next;
					last_on_time_q[item.channel]  <= item.timestamp;
					last_on_valid_q[item.channel] <= 1'b1;
				end else begin
					run_time_q[item.channel]      <= '0;
					last_on_time_q[item.channel]  <= '0;
					last_on_valid_q[item.channel] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item_pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop) begin
			out_data_q <= res;
		end
	end

endmodule

// ----- rtl/adc_frame_ontime_meter_core.sv -----
// Top level of the ADC frame on-time meter.
// Depends on afom_pkg, afom_front, afom_queue and afom_back.
//
// Takes one beat per cycle unless in_stall is high; one result beat for each.
// A sample beat carries a channel (0 or 1), a raw 32-bit serial ADC frame
// (first byte in bits 31..24) and a millisecond timestamp. A frame with the
// null bit (bit 29) set is flagged with frame_error and changes no state.
// Otherwise the 12-bit MSB-first and LSB-first samples are unpacked; the
// MSB-first sample is compared against the channel floor register. At or
// below the floor the channel goes off and its run time clears; above it,
// run time and unreported total both grow by the time since the previous on
// sample (zero if time went backward), or by 1 when the channel was off,
// saturating at all ones. A clear beat zeroes the unreported totals of both
// channels and reports the selected channel's state with unreported_ms = 0.
// Throughput is one beat per cycle while the output is not stalled, set by
// the read-modify-write of the per-channel state in the back end. The
// accepting edge writes the classified beat into a two-entry queue; the
// back end pops it when no stalled result is pending, updates the channel
// and registers the result. in_stall rises only when the queue is full: in
// steady back-to-back flow one beat sits in the queue, and a stalled pending
// result fills it while beats keep arriving.
// Floor registers (index 0 and 1, 12 bits, reset 0) may be written only
// while the block is idle.
module adc_frame_ontime_meter_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  afom_pkg::in_item_t                    in_data,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output afom_pkg::out_item_t                   out_data,
	input  logic                                  cfg_we,
	input  logic [afom_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
	input  logic [afom_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);
	import afom_pkg::*;

	work_item_t front_item;
	work_item_t head_item;
	logic       q_full;
	logic       q_not_empty;
	logic       q_pop;
	logic       in_accept;

	// queue full is registered, so stall never depends on valid
	assign in_stall  = q_full;
	assign in_accept = in_valid && !q_full;

	afom_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (front_item)
	);

	afom_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_accept),
		.push_item (front_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (head_item)
	);

	afom_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_not_empty),
		.item       (head_item),
		.item_pop   (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for adc_frame_ontime_meter_core.
// Depends on afom_pkg and the RTL; a built-in predictor checks every result beat.

module testbench;
	import afom_pkg::*;

	// DUT registers the result after accept; give the tail some margin
	localparam int PIPE_LATENCY   = 1;
	localparam int TAIL_CYCLES    = 10;
	// quiet stretches come from idle bursts, stall bursts and register write pauses
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_BEATS    = 160;
	localparam int NUM_PHASES     = 5;
	localparam logic [TIME_WIDTH-1:0]   TIME_MAX  = '1;
	localparam logic [SAMPLE_WIDTH-1:0] LEVEL_MAX = '1;
	// MSB-first sample sits just below the null bit: frame[28:17]
	localparam int LEVEL_TOP = NULL_BIT_POS - 1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
	logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;

	adc_frame_ontime_meter_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor: own copy of floors and per-channel on-time state.
	// Floors follow the config port as the DUT sees it (mirrored at posedge).
	// ------------------------------------------------------------------
	logic [SAMPLE_WIDTH-1:0] m_floor [NUM_CHAN];
	logic [TIME_WIDTH-1:0]   m_last_on [NUM_CHAN];
	logic                    m_on [NUM_CHAN];
	logic [TIME_WIDTH-1:0]   m_run [NUM_CHAN];
	logic [TIME_WIDTH-1:0]   m_unrep [NUM_CHAN];

	initial begin
		for (int c = 0; c < NUM_CHAN; c++) begin
			m_floor[c]   = '0;
			m_last_on[c] = '0;
			m_on[c]      = 1'b0;
			m_run[c]     = '0;
			m_unrep[c]   = '0;
		end
	end

	function automatic logic [TIME_WIDTH-1:0] sat_sum(
		input logic [TIME_WIDTH-1:0] a,
		input logic [TIME_WIDTH-1:0] b
	);
		if (a > TIME_MAX - b)
			return TIME_MAX;
		return a + b;
	endfunction

	// Applies one accepted beat to the predictor state, returns the reading.
	function automatic out_item_t meter_step(input in_item_t beat);
		out_item_t rd;
		logic [CHAN_WIDTH-1:0] ch;
		logic [7:0] b0, b1, b2, b3;
		logic [SAMPLE_WIDTH-1:0] lsb;
		logic [TIME_WIDTH-1:0] span;
		int i;
		rd = '0;
		ch = beat.channel;
		{b0, b1, b2, b3} = beat.frame;
		if (beat.operation == OP_CLEAR) begin
			for (i = 0; i < NUM_CHAN; i++)
				m_unrep[i] = '0;
		end else if (beat.frame[NULL_BIT_POS]) begin
			// rejected frame: flag only, state untouched
			rd.frame_error = 1'b1;
		end else begin
			rd.sample_msb_first = {b0[4:0], b1[7:1]};
			// LSB-first: b1[1], b1[0], b2[7..0], b3[7], b3[6]
			for (i = 0; i < SAMPLE_WIDTH; i++) begin
				if (i < 2)
					lsb[i] = b1[1 - i];
				else if (i < 10)
					lsb[i] = b2[9 - i];
				else
					lsb[i] = b3[17 - i];
			end
			rd.sample_lsb_first = lsb;
			if (rd.sample_msb_first <= m_floor[ch]) begin
				m_run[ch]     = '0;
				m_on[ch]      = 1'b0;
				m_last_on[ch] = '0;
			end else begin
				// backward time counts as zero; first on sample counts as 1 ms
				if (m_on[ch])
					span = (beat.timestamp_ms >= m_last_on[ch]) ?
						beat.timestamp_ms - m_last_on[ch] : '0;
				else
					span = TIME_WIDTH'(1);
				m_run[ch]     = sat_sum(m_run[ch], span);
				m_unrep[ch]   = sat_sum(m_unrep[ch], span);
				m_last_on[ch] = beat.timestamp_ms;
				m_on[ch]      = 1'b1;
			end
		end
		rd.channel_on    = m_on[ch];
		rd.run_time_ms   = m_run[ch];
		rd.unreported_ms = m_unrep[ch];
		return rd;
	endfunction

	// ------------------------------------------------------------------
	// Driver: pops pending beats, inserts random idle bursts.
	// ------------------------------------------------------------------
	in_item_t frame_beats [$];
	int  beats_left = 0;      // queued but not yet accepted
	logic in_taken = 1'b0;    // previous rising edge accepted the beat on in_data
	int  gap_left = 0;
	int  gap_pct = 0;
	int  stall_left = 0;
	int  stall_pct = 0;

	always @(negedge clk) begin
		if (in_valid && !in_taken) begin
			// stalled: hold valid and payload
		end else if (gap_left > 0) begin
			in_valid <= 1'b0;
			gap_left--;
		end else if (frame_beats.size() != 0 && gap_pct != 0 &&
				$urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			gap_left = $urandom_range(0, 6);
		end else if (frame_beats.size() != 0) begin
			in_valid <= 1'b1;
			in_data  <= frame_beats.pop_front();
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Receiver back-pressure, same burst shape
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(0, 6);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: predicts on input accept, checks on output accept, watchdog.
	// ------------------------------------------------------------------
	out_item_t predicted_readings [$];
	out_item_t want;
	int err_count = 0;
	int idle_cycles = 0;

	always @(posedge clk) begin
		in_taken <= in_valid && !in_stall;
		if (arst_n) begin
			if (cfg_we)
				m_floor[cfg_index] = cfg_data;
			if (out_valid && !out_stall) begin
				if (predicted_readings.size() == 0) begin
					err_count++;
					if (err_count <= 10)
						$display("unexpected result beat at %0t", $time);
				end else begin
					want = predicted_readings.pop_front();
					if (out_data.frame_error      !== want.frame_error      ||
					    out_data.sample_msb_first !== want.sample_msb_first ||
					    out_data.sample_lsb_first !== want.sample_lsb_first ||
					    out_data.channel_on       !== want.channel_on       ||
					    out_data.run_time_ms      !== want.run_time_ms      ||
					    out_data.unreported_ms    !== want.unreported_ms) begin
						err_count++;
						if (err_count <= 10) begin
							$display("mismatch at %0t: want err=%0d msb=%h lsb=%h on=%0d run=%h unrep=%h",
								$time, want.frame_error, want.sample_msb_first,
								want.sample_lsb_first, want.channel_on,
								want.run_time_ms, want.unreported_ms);
							$display("                 got  err=%0d msb=%h lsb=%h on=%0d run=%h unrep=%h",
								out_data.frame_error, out_data.sample_msb_first,
								out_data.sample_lsb_first, out_data.channel_on,
								out_data.run_time_ms, out_data.unreported_ms);
						end
					end
				end
			end
			if (in_valid && !in_stall) begin
				predicted_readings.push_back(meter_step(in_data));
				beats_left--;
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	logic [SAMPLE_WIDTH-1:0] floor_set [NUM_CHAN];
	logic [TIME_WIDTH-1:0]   now_ms = '0;
	logic                    chan_mode [NUM_CHAN];   // bias toward on runs

	task automatic push_beat(input logic op, input logic [CHAN_WIDTH-1:0] ch,
			input logic [FRAME_WIDTH-1:0] frame, input logic [TIME_WIDTH-1:0] ts);
		in_item_t b;
		b.operation    = op;
		b.channel      = ch;
		b.frame        = frame;
		b.timestamp_ms = ts;
		frame_beats.push_back(b);
		beats_left++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
			input logic [CFG_DATA_WIDTH-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic set_floors(input logic [SAMPLE_WIDTH-1:0] f0,
			input logic [SAMPLE_WIDTH-1:0] f1);
		floor_set[0] = f0;
		floor_set[1] = f1;
		write_reg(REG_FLOOR_CHAN0, f0);
		write_reg(REG_FLOOR_CHAN1, f1);
	endtask

	// sender holds off until every reading is back, then pipeline drains
	task automatic drain();
		do @(negedge clk);
		while (beats_left != 0 || predicted_readings.size() != 0);
		repeat (PIPE_LATENCY + 1) @(negedge clk);
	endtask

	// Mostly well-formed samples with runs of on/off per channel; some clears,
	// rejected frames, backward time and large jumps mixed in.
	task automatic random_phase(input int count);
		logic [63:0] r64;
		logic [FRAME_WIDTH-1:0] fr;
		logic [CHAN_WIDTH-1:0] ch;
		logic [SAMPLE_WIDTH-1:0] fl, level;
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			r64  = {$urandom, $urandom};
			fr   = $urandom;
			ch   = CHAN_WIDTH'($urandom_range(0, NUM_CHAN - 1));
			if (pick < 60)
				now_ms = now_ms + $urandom_range(0, 500);
			else if (pick < 64)
				now_ms = now_ms - $urandom_range(0, 300);
			else if (pick < 66)
				now_ms = r64[TIME_WIDTH-1:0];
			else
				now_ms = now_ms + $urandom_range(0, 20);
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				push_beat(OP_CLEAR, ch, fr, r64[TIME_WIDTH-1:0]);
			end else if (pick < 10) begin
				fr[NULL_BIT_POS] = 1'b1;
				push_beat(OP_SAMPLE, ch, fr, now_ms);
			end else begin
				if ($urandom_range(0, 9) == 0)
					chan_mode[ch] = ~chan_mode[ch];
				fl = floor_set[ch];
				pick = $urandom_range(0, 99);
				if (pick < 8)
					level = fl;
				else if (pick < 16)
					level = (fl == LEVEL_MAX) ? fl : fl + 1'b1;
				else if (chan_mode[ch] && fl != LEVEL_MAX)
					level = SAMPLE_WIDTH'($urandom_range(int'(fl) + 1, int'(LEVEL_MAX)));
				else
					level = SAMPLE_WIDTH'($urandom_range(0, int'(fl)));
				fr[LEVEL_TOP -: SAMPLE_WIDTH] = level;
				fr[NULL_BIT_POS] = 1'b0;
				push_beat(OP_SAMPLE, ch, fr, now_ms);
			end
		end
	endtask

	logic [SAMPLE_WIDTH-1:0] ph_floor0 [NUM_PHASES];
	logic [SAMPLE_WIDTH-1:0] ph_floor1 [NUM_PHASES];
	int ph_gap [NUM_PHASES];
	int ph_stall [NUM_PHASES];

	initial begin
		chan_mode[0] = 1'b1;
		chan_mode[1] = 1'b0;
		floor_set[0] = '0;
		floor_set[1] = '0;
		// floor extremes, near-extremes, midscale and random values; last phase has no idling
		ph_floor0 = '{LEVEL_MAX, LEVEL_MAX - 1'b1, 12'($urandom), '0, 12'($urandom)};
		ph_floor1 = '{LEVEL_MAX, '0, 12'($urandom), LEVEL_MAX, 12'h800};
		ph_gap    = '{12, 0, 25, 10, 0};
		ph_stall  = '{12, 20, 0, 30, 0};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part at reset floors (both 0)
		gap_pct   = 10;
		stall_pct = 10;
		// level 0 at floor 0: stays off; all-ones frame with null bit clear
		push_beat(OP_SAMPLE, 1'b0, 32'h0000_0000, '0);
		// on at timestamp zero, then a 100 ms step
		push_beat(OP_SAMPLE, 1'b0, 32'hDFFF_FFFF, '0);
		push_beat(OP_SAMPLE, 1'b0, 32'hDFFF_FFFF, 48'd100);
		// time goes backward: no growth
		push_beat(OP_SAMPLE, 1'b0, 32'h0002_0000, 48'd50);
		// rejected frames, both channels
		push_beat(OP_SAMPLE, 1'b0, 32'hFFFF_FFFF, 48'd200);
		push_beat(OP_SAMPLE, 1'b1, 32'h2000_0000, 48'd200);
		// clear with junk frame and timestamp
		push_beat(OP_CLEAR, 1'b0, 32'hFFFF_FFFF, TIME_MAX);
		// ch1 saturates both sums, holds, then drops off
		push_beat(OP_SAMPLE, 1'b1, 32'hDFFF_FFFF, '0);
		push_beat(OP_SAMPLE, 1'b1, 32'hDFFF_FFFF, TIME_MAX);
		push_beat(OP_SAMPLE, 1'b1, 32'hDFFF_FFFF, TIME_MAX);
		push_beat(OP_SAMPLE, 1'b1, 32'h0000_0000, TIME_MAX);
		push_beat(OP_SAMPLE, 1'b1, 32'h0001_FFFF, TIME_MAX);
		push_beat(OP_CLEAR, 1'b1, 32'h0000_0000, '0);
		// bit-order patterns for both unpackers
		push_beat(OP_SAMPLE, 1'b0, 32'h1F00_0000, 48'd300);
		push_beat(OP_SAMPLE, 1'b0, 32'h00AA_55C0, 48'd301);
		push_beat(OP_SAMPLE, 1'b0, 32'h0055_AA3F, 48'd302);
		push_beat(OP_SAMPLE, 1'b1, 32'h0001_0080, 48'd303);
		push_beat(OP_SAMPLE, 1'b0, 32'hC0FE_FF00, TIME_MAX);
		push_beat(OP_SAMPLE, 1'b0, 32'hDFFF_FFFF, TIME_MAX - 1'b1);
		push_beat(OP_CLEAR, 1'b1, 32'hDEAD_BEEF, 48'd1);
		drain();

		for (int p = 0; p < NUM_PHASES; p++) begin
			set_floors(ph_floor0[p], ph_floor1[p]);
			gap_pct   = ph_gap[p];
			stall_pct = ph_stall[p];
			random_phase(PHASE_BEATS);
			drain();
		end

		repeat (TAIL_CYCLES) @(negedge clk);
		if (err_count == 0 && predicted_readings.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/afom_pkg.sv
rtl/afom_front.sv
rtl/afom_queue.sv
rtl/afom_back.sv
rtl/adc_frame_ontime_meter_core.sv
dv/testbench.sv
